// ===== rtl/llwt_pkg.sv =====
// ----------------------------------------------------------------------------
// llwt_pkg
// Shared types and codes of the least-loaded worker table.
// ----------------------------------------------------------------------------
package llwt_pkg;

  localparam int unsigned MaxWorkersDefault = 16;
  localparam int unsigned PortW = 16;
  localparam int unsigned LoadW = 31;

  localparam logic [LoadW-1:0] LoadMax = {LoadW{1'b1}};

  // Request commands.
  localparam logic [1:0] CMD_ADD_WORKER = 2'd0;
  localparam logic [1:0] CMD_ADD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FIND_MIN   = 2'd2;
  localparam logic [1:0] CMD_REBALANCE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [PortW-1:0] recv_port;
    logic [PortW-1:0] send_port;
    logic [LoadW-1:0] load;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PortW-1:0] min_recv_port;
    logic [PortW-1:0] max_send_port;
    logic [LoadW-1:0] moved_amount;
    logic             balanced;
  } res_t;

endpackage

// ===== rtl/llwt_mem.sv =====
// ----------------------------------------------------------------------------
// llwt_mem
// Worker table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module llwt_mem
  import llwt_pkg::*;
#(
  parameter int unsigned Depth = MaxWorkersDefault,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/llwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// llwt_ctrl
// Command sequencer: decodes a request, scans the table one entry per cycle
// and writes new entries and updated loads back.
// ----------------------------------------------------------------------------
module llwt_ctrl
  import llwt_pkg::*;
#(
  parameter int unsigned MaxWorkers = MaxWorkersDefault,
  parameter int unsigned IdxW       = (MaxWorkers > 1) ? $clog2(MaxWorkers) : 1,
  parameter int unsigned CntW       = $clog2(MaxWorkers + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [PortW-1:0] recv_port_i,
  input  logic [PortW-1:0] send_port_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output logic             we_o,
  output logic [IdxW-1:0]  waddr_o,
  output entry_t           wdata_o,
  output logic [IdxW-1:0]  raddr_o,
  input  entry_t           rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_REB  = 3'd2;
  localparam logic [2:0] S_WRLO = 3'd3;
  localparam logic [2:0] S_WRHI = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [CntW-1:0] CntFull = CntW'(MaxWorkers);

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [PortW-1:0] rport_q, rport_d;
  logic [IdxW-1:0]  scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]  min_idx_q, min_idx_d, max_idx_q, max_idx_d;
  entry_t           min_ent_q, min_ent_d, max_ent_q, max_ent_d;
  logic [LoadW-1:0] moved_q, moved_d;
  res_t             res_q, res_d;

  logic             accept;
  logic             first_elem, last_elem, take_min, take_max;
  logic [LoadW-1:0] diff;
  entry_t           wr_ent;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);
  assign first_elem = (scan_idx_q == '0);
  assign last_elem  = (CntW'(scan_idx_q) == cnt_q - CntW'(1));
  // Strict compares keep the earliest entry on a tie.
  assign take_min   = first_elem || (rdata_i.load < min_ent_q.load);
  assign take_max   = first_elem || (rdata_i.load > max_ent_q.load);
  assign diff       = max_ent_q.load - min_ent_q.load;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    rport_d    = rport_q;
    scan_idx_d = scan_idx_q;
    min_idx_d  = min_idx_q;
    min_ent_d  = min_ent_q;
    max_idx_d  = max_idx_q;
    max_ent_d  = max_ent_q;
    moved_d    = moved_q;
    res_d      = res_q;
    we_o       = 1'b0;
    waddr_o    = scan_idx_q;
    wr_ent     = rdata_i;
    raddr_o    = scan_idx_q;

    case (state_q)
      S_IDLE: begin
        raddr_o = (cmd_i == CMD_ADD_DATA) ? IdxW'(cnt_q - CntW'(1)) : '0;
        if (accept) begin
          cmd_d      = cmd_i;
          rport_d    = recv_port_i;
          scan_idx_d = raddr_o;
          res_d      = '0;
          if (cmd_i == CMD_ADD_WORKER) begin
            state_d = S_DONE;
            if (cnt_q == CntFull) begin
              res_d.status = ST_FULL;
            end else begin
              we_o    = 1'b1;
              waddr_o = IdxW'(cnt_q);
              wr_ent  = '{recv_port: recv_port_i, send_port: send_port_i, load: '0};
              cnt_d   = cnt_q + CntW'(1);
            end
          end else if (cnt_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cmd_q == CMD_ADD_DATA) begin
          // Newest entry first, so the scan walks down from the top.
          raddr_o = scan_idx_q - IdxW'(1);
          if (rdata_i.recv_port == rport_q) begin
            we_o    = 1'b1;
            waddr_o = scan_idx_q;
            if (rdata_i.load != LoadMax) begin
              wr_ent.load = rdata_i.load + LoadW'(1);
            end
            state_d = S_DONE;
          end else if (first_elem) begin
            res_d.status = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            scan_idx_d = scan_idx_q - IdxW'(1);
          end
        end else begin
          raddr_o = scan_idx_q + IdxW'(1);
          if (take_min) begin
            min_idx_d = scan_idx_q;
            min_ent_d = rdata_i;
          end
          if (take_max) begin
            max_idx_d = scan_idx_q;
            max_ent_d = rdata_i;
          end
          if (last_elem) begin
            if (cmd_q == CMD_FIND_MIN) begin
              res_d.min_recv_port = take_min ? rdata_i.recv_port : min_ent_q.recv_port;
              state_d             = S_DONE;
            end else begin
              state_d = S_REB;
            end
          end else begin
            scan_idx_d = scan_idx_q + IdxW'(1);
          end
        end
      end

      S_REB: begin
        res_d.min_recv_port = min_ent_q.recv_port;
        res_d.max_send_port = max_ent_q.send_port;
        moved_d             = diff >> 1;
        if (diff > LoadW'(1)) begin
          state_d = S_WRLO;
        end else begin
          res_d.balanced = 1'b1;
          state_d        = S_DONE;
        end
      end

      S_WRLO: begin
        we_o        = 1'b1;
        waddr_o     = min_idx_q;
        wr_ent      = min_ent_q;
        wr_ent.load = min_ent_q.load + moved_q;
        state_d     = S_WRHI;
      end

      S_WRHI: begin
        we_o               = 1'b1;
        waddr_o            = max_idx_q;
        wr_ent             = max_ent_q;
        wr_ent.load        = max_ent_q.load - moved_q;
        res_d.moved_amount = moved_q;
        state_d            = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign wdata_o     = wr_ent;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rport_q    <= rport_d;
    scan_idx_q <= scan_idx_d;
    min_idx_q  <= min_idx_d;
    min_ent_q  <= min_ent_d;
    max_idx_q  <= max_idx_d;
    max_ent_q  <= max_ent_d;
    moved_q    <= moved_d;
    res_q      <= res_d;
  end

endmodule

// ===== rtl/least_loaded_worker_table.sv =====
// Requests are taken one at a time, and the scan reads one table entry per cycle.
// Reset clears the worker count and the control state; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// least_loaded_worker_table
// Worker table with add, add-data, find-least-loaded and rebalance requests.
// ----------------------------------------------------------------------------
module least_loaded_worker_table
  import llwt_pkg::*;
#(
  parameter int unsigned MaxWorkers = MaxWorkersDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [PortW-1:0] recv_port_i,
  input  logic [PortW-1:0] send_port_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [PortW-1:0] min_recv_port_o,
  output logic [PortW-1:0] max_send_port_o,
  output logic [LoadW-1:0] moved_amount_o,
  output logic             balanced_o
);

  localparam int unsigned IdxW = (MaxWorkers > 1) ? $clog2(MaxWorkers) : 1;
  localparam int unsigned CntW = $clog2(MaxWorkers + 1);

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic            res_valid, res_ready;
  res_t            res;
  logic            out_valid_q;
  res_t            out_res_q;

  llwt_ctrl #(
    .MaxWorkers(MaxWorkers),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .recv_port_i(recv_port_i),
    .send_port_i(send_port_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  llwt_mem #(
    .Depth(MaxWorkers),
    .IdxW (IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Output register lets the sequencer take the next request while a result waits.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_res_q.status;
  assign min_recv_port_o = out_res_q.min_recv_port;
  assign max_send_port_o = out_res_q.max_send_port;
  assign moved_amount_o  = out_res_q.moved_amount;
  assign balanced_o      = out_res_q.balanced;

endmodule

// ===== rtl/llwt_checker.sv =====
// ----------------------------------------------------------------------------
// llwt_checker
// Port-level checks of the least-loaded worker table, bound to the top level.
// ----------------------------------------------------------------------------
module llwt_checker
  import llwt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [1:0]       cmd_i,
  input logic [PortW-1:0] recv_port_i,
  input logic [PortW-1:0] send_port_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       status_o,
  input logic [PortW-1:0] min_recv_port_o,
  input logic [PortW-1:0] max_send_port_o,
  input logic [LoadW-1:0] moved_amount_o,
  input logic             balanced_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(min_recv_port_o) && $stable(max_send_port_o) &&
      $stable(moved_amount_o) && $stable(balanced_o))
    else $error("result changed while stalled");

  // Only one request is in flight, so an accepted request blocks the next.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // Error results carry no other information.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      min_recv_port_o == '0 && max_send_port_o == '0 &&
      moved_amount_o == '0 && !balanced_o)
    else $error("error result with nonzero fields");

  // A balanced table moves nothing.
  a_bal_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && balanced_o |-> moved_amount_o == '0 && status_o == ST_OK)
    else $error("balanced result reports a move");

endmodule

bind least_loaded_worker_table llwt_checker u_llwt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .cmd_i          (cmd_i),
  .recv_port_i    (recv_port_i),
  .send_port_i    (send_port_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .min_recv_port_o(min_recv_port_o),
  .max_send_port_o(max_send_port_o),
  .moved_amount_o (moved_amount_o),
  .balanced_o     (balanced_o)
);

// ===== sim/llwt_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwt_scoreboard_pkg
// Tracks the worker table as requests are accepted, works out the result of
// each request and checks the block's results against them in order.
// ----------------------------------------------------------------------------
package llwt_scoreboard_pkg;
  import llwt_pkg::*;

  localparam int NumSlots = MaxWorkersDefault;

  class worker_table_scoreboard;
    logic [PortW-1:0] port_rx[NumSlots];
    logic [PortW-1:0] port_tx[NumSlots];
    logic [LoadW-1:0] load[NumSlots];
    int               workers;
    int               errors;
    res_t             pending_results[$];

    function new();
      workers = 0;
      errors  = 0;
    endfunction

    // Index of the earliest entry with the smallest or the largest load.
    function int pick_extreme(bit want_max);
      int best;
      int i;
      best = 0;
      for (i = 1; i < workers; i++) begin
        if (want_max ? (load[i] > load[best]) : (load[i] < load[best])) begin
          best = i;
        end
      end
      return best;
    endfunction

    function void note_request(logic [1:0] cmd, logic [PortW-1:0] rx,
                               logic [PortW-1:0] tx);
      res_t             want;
      int               i;
      int               lo;
      int               hi;
      bit               hit;
      logic [LoadW-1:0] spread;
      want = '0;
      if (cmd == CMD_ADD_WORKER) begin
        if (workers >= NumSlots) begin
          want.status = ST_FULL;
        end else begin
          port_rx[workers] = rx;
          port_tx[workers] = tx;
          load[workers]    = '0;
          workers++;
        end
      end else if (workers == 0) begin
        want.status = ST_EMPTY;
      end else if (cmd == CMD_ADD_DATA) begin
        // The newest entry with a matching receive port takes the data.
        hit = 1'b0;
        for (i = workers - 1; i >= 0 && !hit; i--) begin
          if (port_rx[i] == rx) begin
            if (load[i] != LoadMax) begin
              load[i] = load[i] + LoadW'(1);
            end
            hit = 1'b1;
          end
        end
        if (!hit) begin
          want.status = ST_NOT_FOUND;
        end
      end else if (cmd == CMD_FIND_MIN) begin
        want.min_recv_port = port_rx[pick_extreme(1'b0)];
      end else begin
        lo     = pick_extreme(1'b0);
        hi     = pick_extreme(1'b1);
        spread = load[hi] - load[lo];
        want.min_recv_port = port_rx[lo];
        want.max_send_port = port_tx[hi];
        if (spread > LoadW'(1)) begin
          want.moved_amount = spread >> 1;
          load[lo] = load[lo] + want.moved_amount;
          load[hi] = load[hi] - want.moved_amount;
        end else begin
          want.balanced = 1'b1;
        end
      end
      pending_results.push_back(want);
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting, status %0h", $time, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("min_recv_port", 64'(want.min_recv_port), 64'(got.min_recv_port));
      check_field("max_send_port", 64'(want.max_send_port), 64'(got.max_send_port));
      check_field("moved_amount", 64'(want.moved_amount), 64'(got.moved_amount));
      check_field("balanced", 64'(want.balanced), 64'(got.balanced));
    endfunction
  endclass

endpackage

// ===== sim/least_loaded_worker_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_worker_table_test
// Drives add, add-data, find and rebalance requests into the worker table
// with random gaps on both handshakes and checks every result in order.
// ----------------------------------------------------------------------------
module least_loaded_worker_table_test;
  import llwt_pkg::*;
  import llwt_scoreboard_pkg::*;

  localparam int RandomRequests = 1650;
  localparam int IdleLimit      = 3000;
  localparam int DrainCycles    = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       cmd_i;
  logic [PortW-1:0] recv_port_i;
  logic [PortW-1:0] send_port_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       status_o;
  logic [PortW-1:0] min_recv_port_o;
  logic [PortW-1:0] max_send_port_o;
  logic [LoadW-1:0] moved_amount_o;
  logic             balanced_o;

  worker_table_scoreboard board;
  bit                     steady;
  int                     busy_slot;
  int                     idle_cycles;

  least_loaded_worker_table DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .recv_port_i,
    .send_port_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .min_recv_port_o,
    .max_send_port_o,
    .moved_amount_o,
    .balanced_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none during a steady stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [PortW-1:0] rx, logic [PortW-1:0] tx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    recv_port_i <= rx;
    send_port_i <= tx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(cmd, rx, tx);
  endtask

  task automatic send_random_request();
    int               roll;
    int               slot;
    logic [1:0]       cmd;
    logic [PortW-1:0] rx;
    logic [PortW-1:0] tx;
    roll = $urandom_range(0, 99);
    rx   = PortW'($urandom());
    tx   = PortW'($urandom());
    if (board.workers > 0) begin
      slot = ($urandom_range(0, 2) == 0) ? busy_slot
                                         : int'($urandom_range(0, board.workers - 1));
      if (slot >= board.workers) begin
        slot = board.workers - 1;
      end
    end
    if (roll < 5 || (board.workers < 2 && roll < 25)) begin
      cmd = CMD_ADD_WORKER;
      // Some workers share a receive port so that the newest one must win.
      if (board.workers > 0 && $urandom_range(0, 3) == 0) begin
        rx = board.port_rx[slot];
      end
    end else if (roll < 70) begin
      cmd = CMD_ADD_DATA;
      if (board.workers > 0 && roll >= 13) begin
        rx = board.port_rx[slot];
      end
    end else if (roll < 84) begin
      cmd = CMD_FIND_MIN;
    end else begin
      cmd = CMD_REBALANCE;
    end
    send_request(cmd, rx, tx);
  endtask

  // Result side: ready stalls at random, apart from the request side; neither stalls during a steady stretch.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status        = status_o;
      got.min_recv_port = min_recv_port_o;
      got.max_send_port = max_send_port_o;
      got.moved_amount  = moved_amount_o;
      got.balanced      = balanced_o;
      board.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_ADD_WORKER;
    recv_port_i = '0;
    send_port_i = '0;
    steady      = 1'b0;
    busy_slot   = 0;
    board       = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every request on an empty table reports empty, except add worker.
    send_request(CMD_ADD_DATA, 16'h1234, 16'h4321);
    send_request(CMD_FIND_MIN, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_REBALANCE, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_ADD_WORKER, 16'hFFFF, 16'h0000);
    send_request(CMD_ADD_WORKER, 16'h0000, 16'hFFFF);
    // Equal loads: the first worker added wins both the minimum and maximum.
    send_request(CMD_FIND_MIN, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_REBALANCE, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_ADD_DATA, 16'h0000, PortW'($urandom()));
    send_request(CMD_ADD_DATA, 16'h5555, PortW'($urandom()));
    send_request(CMD_REBALANCE, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_ADD_DATA, 16'h0000, PortW'($urandom()));
    send_request(CMD_ADD_DATA, 16'h0000, PortW'($urandom()));
    send_request(CMD_REBALANCE, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_ADD_WORKER, 16'h0000, 16'hAAAA);
    send_request(CMD_ADD_DATA, 16'h0000, PortW'($urandom()));
    send_request(CMD_FIND_MIN, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_ADD_WORKER, 16'hA5A5, 16'h5A5A);
    send_request(CMD_FIND_MIN, PortW'($urandom()), PortW'($urandom()));
    send_request(CMD_REBALANCE, PortW'($urandom()), PortW'($urandom()));

    for (n = 0; n < RandomRequests; n++) begin
      if (n % 64 == 0) begin
        steady    = $urandom_range(0, 4) == 0;
        busy_slot = $urandom_range(0, NumSlots - 1);
      end
      send_random_request();
    end
    in_valid_i <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/llwt_pkg.sv
rtl/llwt_mem.sv
rtl/llwt_ctrl.sv
rtl/least_loaded_worker_table.sv
rtl/llwt_checker.sv
sim/llwt_scoreboard_pkg.sv
sim/least_loaded_worker_table_test.sv
